[rtl/rft_pkg.sv]
// Shared constants and control/status types for the rail fence transposition block.
package rft_pkg;

  localparam int MAX_BLOCK = 64;
  localparam int ADDR_W    = $clog2(MAX_BLOCK);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int CHAR_W    = 8;
  localparam int RAILS_W   = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = RAILS_W;

  localparam logic [CFG_IDX_W-1:0] REG_RAILS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT = 1'b1;

  localparam logic [RAILS_W-1:0] RAILS_RESET = 7'd3;
  localparam logic [RAILS_W-1:0] RAILS_MIN   = 7'd2;

  typedef struct packed {
    logic load;
    logic start;
    logic scat;
    logic emit;
    logic rewind;
  } rft_cmd_t;

  typedef struct packed {
    logic close;
    logic decrypt;
    logic last;
    logic out_free;
  } rft_stat_t;

endpackage

[rtl/rail_fence_transposition.sv]
// Top level: rail fence transposition of byte blocks up to 64 bytes.
// Flow: encrypt emits the block after the closing transaction; decrypt first runs a
//   scatter pass over the block and a drain state before it emits.
// Throughput: one byte per cycle while loading, and while emitting unless the output
//   is stalled. Input is held off while a block is scattered or emitted.
// Reset: clears control, rails to 3, encrypt mode; buffers need no clearing pass.
module rail_fence_transposition import rft_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [CHAR_W-1:0]    in_tdata,   // [7:0] char_in
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [CHAR_W-1:0]    out_tdata,  // [7:0] char_out
  output logic                 out_tlast
);

  rft_cmd_t  cmd;
  rft_stat_t stat;

  rft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rft_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .char_in      (in_tdata),
    .end_of_block (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .char_out     (out_tdata),
    .last_out     (out_tlast),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

[rtl/rft_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/rft_ctrl.sv]
// Controller state machine: load, scatter pass, drain, emit.
module rft_ctrl import rft_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  rft_stat_t stat,
  output rft_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_SCATTER,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
        if (in_tvalid && stat.close) begin
          cmd.start = 1'b1;
          state_nxt = stat.decrypt ? S_SCATTER : S_EMIT;
        end
      end
      S_SCATTER: begin
        cmd.scat = 1'b1;
        if (stat.last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.rewind = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = stat.out_free;
        if (stat.out_free && stat.last) begin
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/rft_dp.sv]
// Datapath: config registers, block buffers, rail order generator and output stage.
module rft_dp import rft_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [CHAR_W-1:0]    char_in,
  input  logic                 end_of_block,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [CHAR_W-1:0]    char_out,
  output logic                 last_out,
  input  rft_cmd_t             cmd,
  output rft_stat_t            stat
);

  localparam int STEP_W = RAILS_W + 1;
  localparam int SUM_W  = STEP_W + 1;

  logic [RAILS_W-1:0] rails_r;
  logic               decrypt_r;
  logic [CNT_W-1:0]   fill_r;
  logic [CNT_W-1:0]   n_r;
  logic [RAILS_W-1:0] k_r;
  logic               mode_r;
  logic [ADDR_W-1:0]  rail_r;
  logic [ADDR_W-1:0]  pos_r;
  logic               phase_r;
  logic [ADDR_W-1:0]  j_r;
  logic               scat_wr_r;
  logic [ADDR_W-1:0]  scat_addr_r;
  logic               out_vld_r;
  logic               last_r;

  logic [RAILS_W-1:0] k_eff;
  logic [RAILS_W-1:0] k_top;
  logic [ADDR_W-1:0]  rail_init;
  logic [RAILS_W-1:0] gap;
  logic [STEP_W-1:0]  first_step;
  logic [STEP_W-1:0]  second_step;
  logic [STEP_W-1:0]  step_a;
  logic [STEP_W-1:0]  step_e;
  logic               skip;
  logic [SUM_W-1:0]   pos_sum;
  logic               rail_done;
  logic [ADDR_W-1:0]  rail_nxt;
  logic [ADDR_W-1:0]  pos_nxt;
  logic               phase_nxt;
  logic               gen_adv;
  logic               buf_re;
  logic [ADDR_W-1:0]  buf_raddr;
  logic [CHAR_W-1:0]  buf_rdata;
  logic               res_re;
  logic [CHAR_W-1:0]  res_rdata;

  // Rail count and first rail for the closing block
  assign k_eff     = (rails_r < RAILS_MIN) ? RAILS_MIN : rails_r;
  assign k_top     = k_eff - RAILS_W'(1);
  assign rail_init = (k_top > fill_r) ? fill_r[ADDR_W-1:0] : k_top[ADDR_W-1:0];

  // Zigzag step: skip a zero step, leave the rail when past the block
  assign gap         = k_r - RAILS_W'(1) - RAILS_W'(rail_r);
  assign first_step  = {gap, 1'b0};
  assign second_step = STEP_W'({rail_r, 1'b0});
  assign step_a      = phase_r ? second_step : first_step;
  assign skip        = (step_a == '0);
  assign step_e      = skip ? (phase_r ? first_step : second_step) : step_a;
  assign pos_sum     = SUM_W'(pos_r) + SUM_W'(step_e);
  assign rail_done   = (pos_sum >= SUM_W'(n_r));

  always_comb begin
    if (rail_done) begin
      rail_nxt  = rail_r - ADDR_W'(1);
      pos_nxt   = rail_r - ADDR_W'(1);
      phase_nxt = 1'b0;
    end else begin
      rail_nxt  = rail_r;
      pos_nxt   = pos_sum[ADDR_W-1:0];
      phase_nxt = skip ? phase_r : ~phase_r;
    end
  end

  assign gen_adv = cmd.scat | (cmd.emit & ~mode_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rails_r   <= RAILS_RESET;
      decrypt_r <= 1'b0;
      fill_r    <= '0;
      scat_wr_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RAILS:   rails_r   <= cfg_data[RAILS_W-1:0];
          REG_DECRYPT: decrypt_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        fill_r <= stat.close ? '0 : fill_r + CNT_W'(1);
      end
      scat_wr_r <= cmd.scat;
      if (cmd.emit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_r     <= fill_r + CNT_W'(1);
      k_r     <= k_eff;
      mode_r  <= decrypt_r;
      rail_r  <= rail_init;
      pos_r   <= rail_init;
      phase_r <= 1'b0;
      j_r     <= '0;
    end else begin
      if (gen_adv) begin
        rail_r  <= rail_nxt;
        pos_r   <= pos_nxt;
        phase_r <= phase_nxt;
      end
      if (cmd.rewind) begin
        j_r <= '0;
      end else if (cmd.scat || cmd.emit) begin
        j_r <= j_r + ADDR_W'(1);
      end
    end
    scat_addr_r <= pos_r;
    if (cmd.emit) begin
      last_r <= stat.last;
    end
  end

  assign buf_re    = cmd.scat | (cmd.emit & ~mode_r);
  assign buf_raddr = cmd.scat ? j_r : pos_r;
  assign res_re    = cmd.emit & mode_r;

  rft_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_BLOCK)) u_buf_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (fill_r[ADDR_W-1:0]),
    .wdata (char_in),
    .re    (buf_re),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  rft_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_BLOCK)) u_res_ram (
    .clk   (clk),
    .we    (scat_wr_r),
    .waddr (scat_addr_r),
    .wdata (buf_rdata),
    .re    (res_re),
    .raddr (j_r),
    .rdata (res_rdata)
  );

  assign stat.close    = end_of_block | (fill_r == CNT_W'(MAX_BLOCK - 1));
  assign stat.decrypt  = decrypt_r;
  assign stat.last     = (j_r == ADDR_W'(n_r - CNT_W'(1)));
  assign stat.out_free = ~out_vld_r | out_tready;

  assign out_tvalid = out_vld_r;
  assign char_out   = mode_r ? res_rdata : buf_rdata;
  assign last_out   = last_r;

endmodule

[bench/testbench.sv]
// Self-checking bench for the rail fence transposition block: directed and random blocks.
`timescale 1ns / 1ps

module testbench;
  import rft_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last_out;
  } out_byte_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_RAILS;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [CHAR_W-1:0]    in_tdata = '0;   // [7:0] char_in
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [CHAR_W-1:0]    out_tdata;       // [7:0] char_out
  logic                 out_tlast;

  out_byte_t         expected_bytes[$];
  logic [CHAR_W-1:0] held_bytes[MAX_BLOCK];
  int                held_count;
  logic [RAILS_W-1:0] key_rails;
  logic              key_decrypt;
  int                mismatch_count = 0;
  int                quiet_cycles = 0;
  int                send_idle_pct = 0;
  int                stall_pct = 0;

  rail_fence_transposition dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Compute the permuted block from the held bytes and queue its bytes.
  function automatic void transpose_block(input int n);
    int        k;
    int        r;
    int        pos;
    int        cnt;
    int        step;
    int        j;
    bit        phase;
    int        order[MAX_BLOCK];
    logic [CHAR_W-1:0] perm[MAX_BLOCK];
    out_byte_t e;
    k = (key_rails < RAILS_MIN) ? 2 : int'(key_rails);
    cnt = 0;
    for (r = k - 1; r >= 0; r--) begin
      if (r < n) begin
        pos = r;
        phase = 1'b0;
        while (pos < n && cnt < n) begin
          order[cnt] = pos;
          cnt++;
          do begin
            step = phase ? 2 * r : 2 * (k - 1 - r);
            phase = ~phase;
            pos += step;
          end while (step == 0);
        end
      end
    end
    for (j = 0; j < n; j++) begin
      if (key_decrypt) begin
        perm[order[j]] = held_bytes[j];
      end else begin
        perm[j] = held_bytes[order[j]];
      end
    end
    for (j = 0; j < n; j++) begin
      e.char_out = perm[j];
      e.last_out = (j == n - 1);
      expected_bytes.push_back(e);
    end
  endfunction

  always @(posedge clk) begin
    out_byte_t e;
    if (!rst_n) begin
      key_rails = RAILS_RESET;
      key_decrypt = 1'b0;
      held_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          note_mismatch($sformatf("unexpected output byte %02h last %b", out_tdata, out_tlast));
        end else begin
          e = expected_bytes.pop_front();
          if (out_tdata !== e.char_out) begin
            note_mismatch($sformatf("char_out: expected %02h, got %02h", e.char_out, out_tdata));
          end
          if (out_tlast !== e.last_out) begin
            note_mismatch($sformatf("last_out: expected %b, got %b", e.last_out, out_tlast));
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_RAILS:   key_rails = cfg_data;
          REG_DECRYPT: key_decrypt = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        held_bytes[held_count] = in_tdata;
        held_count++;
        if (in_tlast || held_count == MAX_BLOCK) begin
          transpose_block(held_count);
          held_count = 0;
        end
      end
    end
  end

  task automatic send_byte(input logic [CHAR_W-1:0] value, input logic mark_last);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= value;
    in_tlast <= mark_last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_block(input int len, input bit mark_last);
    for (int i = 0; i < len; i++) begin
      send_byte(CHAR_W'($urandom_range(0, 255)), mark_last && (i == len - 1));
    end
  endtask

  // Hold the input until every queued byte has come out, then let the block settle.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_mode(input bit decrypt);
    write_reg(REG_DECRYPT, CFG_W'(($urandom_range(0, 127) & 'h7E) | decrypt));
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h01, 1'b1);
    wait_drained();
  endtask

  task automatic test_single_byte_block();
    send_byte(8'h80, 1'b1);
    wait_drained();
  endtask

  task automatic test_rails_below_two();
    write_reg(REG_RAILS, 7'd0);
    send_block(4, 1'b1);
    wait_drained();
    write_reg(REG_RAILS, 7'd1);
    send_block(3, 1'b1);
    wait_drained();
  endtask

  task automatic test_rails_beyond_block();
    write_reg(REG_RAILS, 7'd127);
    send_block(5, 1'b1);
    wait_drained();
  endtask

  task automatic test_decrypt_scatter();
    write_reg(REG_RAILS, RAILS_MIN);
    set_mode(1'b1);
    send_block(6, 1'b1);
    wait_drained();
  endtask

  task automatic test_full_buffer();
    write_reg(REG_RAILS, 7'd5);
    set_mode(1'b1);
    send_block(MAX_BLOCK, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall, input int items);
    int sent;
    int len;
    int pick;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_drained();
        pick = $urandom_range(0, 9);
        case (pick)
          0: write_reg(REG_RAILS, 7'd0);
          1: write_reg(REG_RAILS, RAILS_MIN);
          2: write_reg(REG_RAILS, 7'd64);
          3: write_reg(REG_RAILS, 7'd127);
          default: write_reg(REG_RAILS, RAILS_W'($urandom_range(2, 16)));
        endcase
        set_mode($urandom_range(0, 1));
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, MAX_BLOCK) : $urandom_range(1, 12);
      send_block(len, 1'b1);
      sent += len;
      if ($urandom_range(0, 4) == 0) begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_single_byte_block();
    test_rails_below_two();
    test_rails_beyond_block();
    test_decrypt_scatter();
    test_random_traffic(0, 0, 10);
    test_random_traffic(69, 0, 10);
    test_random_traffic(0, 69, 10);
    test_random_traffic(30, 30, 10);
    test_full_buffer();

    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
